FILE: hdl/sefs_pkg.sv
// ---------------------------------------------------------------------------
// sefs_pkg: shared types, constants and microcode for the Euler stepper
// Control word layout, sequencer-to-datapath bundle, register defaults
// and the step program ROM.
// ---------------------------------------------------------------------------
package sefs_pkg;

   localparam int DATA_W    = 32;
   localparam int NUM_CSR   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 4;

   // request function codes
   localparam logic FUNC_ADVANCE = 1'b0;
   localparam logic FUNC_LOAD    = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_POS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_VEL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ANG     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_RATE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANG_TO_ACC   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANG_TO_ANGAC = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRV_TO_ACC   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DRV_TO_ANGAC = 3'd7;

   typedef logic [NUM_CSR-1:0][DATA_W-1:0] csr_array_type;

   localparam csr_array_type CSR_RESET = '{
      32'hFFE0_0000,   // drive to angular accel  (-2.0)
      32'h0010_0000,   // drive to accel          ( 1.0)
      32'h0159_4FDF,   // angle to angular accel  (21.58...)
      32'hFFF0_4DD3,   // angle to accel          (-0.98...)
      32'hFFD0_0000,   // gain angular rate       (-3.0)
      32'hFEC0_0000,   // gain angle              (-20.0)
      32'hFFE8_0000,   // gain velocity           (-1.5)
      32'hFFF0_0000    // gain position           (-1.0)
   };

   // state reset: position, velocity, angle (0.1 rad), angular rate
   localparam logic [DATA_W-1:0] X0_RESET = 32'd0;
   localparam logic [DATA_W-1:0] X1_RESET = 32'd0;
   localparam logic [DATA_W-1:0] X2_RESET = 32'd104858;
   localparam logic [DATA_W-1:0] X3_RESET = 32'd0;

   localparam logic [STEP_W-1:0] STEP_LOAD = 4'd13;

   typedef enum logic [3:0] {
      MA_G0, MA_G1, MA_G2, MA_G3, MA_A12, MA_A32, MA_B1, MA_B3,
      MA_X1, MA_X3, MA_R1, MA_R3
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      MB_X0, MB_X1, MB_X2, MB_X3, MB_U, MB_DT
   } mul_b_sel_type;

   typedef enum logic [2:0] {
      AS_ZERO, AS_ACC, AS_R1, AS_R3, AS_X0, AS_X1, AS_X2, AS_X3
   } add_sel_type;

   typedef enum logic [2:0] {
      DS_ACC, DS_R1, DS_R3, DS_X0, DS_X1, DS_X2, DS_X3
   } dst_sel_type;

   typedef struct packed {
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      logic          wb_en;     // retire the previous step's product
      add_sel_type   wb_add;
      dst_sel_type   wb_dst;
      logic          adv_only;  // product clips here do not count for a load
      logic          neg;       // u <= sat(-acc)
      logic          emit;      // capture state and drive into output word
      logic          jmp_load;  // branch to load step on a load word
      logic          load;      // overwrite one state entry
      logic          last;      // word complete
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type cw;
      logic          adv;       // current step executes this cycle
      logic          start;     // request word accepted
      logic          is_load;
   } seq_ctrl_type;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '{mul_a: MA_G0, mul_b: MB_X0, wb_en: 1'b0, wb_add: AS_ZERO,
             wb_dst: DS_ACC, adv_only: 1'b0, neg: 1'b0, emit: 1'b0,
             jmp_load: 1'b0, load: 1'b0, last: 1'b0};
      unique case (step)
         4'd0: begin
            cw.mul_a = MA_G0; cw.mul_b = MB_X0;
         end
         4'd1: begin
            cw.mul_a = MA_G1; cw.mul_b = MB_X1;
            cw.wb_en = 1'b1; cw.wb_add = AS_ZERO; cw.wb_dst = DS_ACC;
         end
         4'd2: begin
            cw.mul_a = MA_G2; cw.mul_b = MB_X2;
            cw.wb_en = 1'b1; cw.wb_add = AS_ACC; cw.wb_dst = DS_ACC;
         end
         4'd3: begin
            cw.mul_a = MA_G3; cw.mul_b = MB_X3;
            cw.wb_en = 1'b1; cw.wb_add = AS_ACC; cw.wb_dst = DS_ACC;
         end
         4'd4: begin
            cw.mul_a = MA_A12; cw.mul_b = MB_X2;
            cw.wb_en = 1'b1; cw.wb_add = AS_ACC; cw.wb_dst = DS_ACC;
         end
         4'd5: begin
            cw.mul_a = MA_A32; cw.mul_b = MB_X2;
            cw.wb_en = 1'b1; cw.wb_add = AS_ZERO; cw.wb_dst = DS_R1;
            cw.adv_only = 1'b1; cw.neg = 1'b1; cw.emit = 1'b1;
            cw.jmp_load = 1'b1;
         end
         4'd6: begin
            cw.mul_a = MA_B1; cw.mul_b = MB_U;
            cw.wb_en = 1'b1; cw.wb_add = AS_ZERO; cw.wb_dst = DS_R3;
         end
         4'd7: begin
            cw.mul_a = MA_B3; cw.mul_b = MB_U;
            cw.wb_en = 1'b1; cw.wb_add = AS_R1; cw.wb_dst = DS_R1;
         end
         4'd8: begin
            cw.mul_a = MA_X1; cw.mul_b = MB_DT;
            cw.wb_en = 1'b1; cw.wb_add = AS_R3; cw.wb_dst = DS_R3;
         end
         4'd9: begin
            cw.mul_a = MA_R1; cw.mul_b = MB_DT;
            cw.wb_en = 1'b1; cw.wb_add = AS_X0; cw.wb_dst = DS_X0;
         end
         4'd10: begin
            cw.mul_a = MA_X3; cw.mul_b = MB_DT;
            cw.wb_en = 1'b1; cw.wb_add = AS_X1; cw.wb_dst = DS_X1;
         end
         4'd11: begin
            cw.mul_a = MA_R3; cw.mul_b = MB_DT;
            cw.wb_en = 1'b1; cw.wb_add = AS_X2; cw.wb_dst = DS_X2;
         end
         4'd12: begin
            cw.wb_en = 1'b1; cw.wb_add = AS_X3; cw.wb_dst = DS_X3;
            cw.last = 1'b1;
         end
         4'd13: begin
            cw.load = 1'b1; cw.last = 1'b1;
         end
         default: begin
            cw.last = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

FILE: hdl/sefs_csr.sv
// ---------------------------------------------------------------------------
// sefs_csr: gain and plant-term register file
// Eight 32-bit registers, written through the plain write port.
// ---------------------------------------------------------------------------
module sefs_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [sefs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sefs_pkg::DATA_W-1:0]            csr_write_data,
   output sefs_pkg::csr_array_type                csr_regs
);

   sefs_pkg::csr_array_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= sefs_pkg::CSR_RESET;
      end else if (csr_write_en) begin
         csr_ff[csr_index] <= csr_write_data;
      end
   end

   assign csr_regs = csr_ff;

endmodule

FILE: hdl/sefs_sequencer.sv
// ---------------------------------------------------------------------------
// sefs_sequencer: step counter and microcode fetch
// Walks the step program, branches on load words, owns the handshakes.
// ---------------------------------------------------------------------------
module sefs_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sefs_pkg::seq_ctrl_type ctrl
);

   logic                          busy_ff, busy_in;
   logic [sefs_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          func_ff, func_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sefs_pkg::ctrl_word_type       cw;
   logic                          stall, adv, start;

   assign cw    = sefs_pkg::ucode(step_ff);
   // emit waits for the output word to be free
   assign stall = cw.emit && rsp_valid_ff && !rsp_ready;
   assign adv   = busy_ff && !stall;
   assign start = req_valid && !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      func_in      = func_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         func_in = req_func;
      end else if (adv) begin
         priority if (cw.last) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else if (cw.jmp_load && (func_ff == sefs_pkg::FUNC_LOAD)) begin
            step_in = sefs_pkg::STEP_LOAD;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         func_ff      <= sefs_pkg::FUNC_ADVANCE;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         func_ff      <= func_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready     = !busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign ctrl.cw       = cw;
   assign ctrl.adv      = adv;
   assign ctrl.start    = start;
   assign ctrl.is_load  = (func_ff == sefs_pkg::FUNC_LOAD);

endmodule

FILE: hdl/sefs_datapath.sv
// ---------------------------------------------------------------------------
// sefs_datapath: shared multiplier, saturating adder and state registers
// One 32x32 product per unstalled cycle; next step rounds, clips, accumulates.
// ---------------------------------------------------------------------------
module sefs_datapath #(
   parameter int FRAC_BITS = 20,
   parameter int DT_FIXED  = 20972
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sefs_pkg::seq_ctrl_type        ctrl,
   input  sefs_pkg::csr_array_type       csr_regs,
   input  logic [1:0]                    req_entry_index,
   input  logic signed [31:0]            req_entry_value,
   output logic signed [31:0]            rsp_position_now,
   output logic signed [31:0]            rsp_velocity_now,
   output logic signed [31:0]            rsp_angle_now,
   output logic signed [31:0]            rsp_angular_rate_now,
   output logic signed [31:0]            rsp_drive_value,
   output logic                          rsp_saturated
);

   localparam logic signed [63:0] RND     = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
   localparam logic signed [31:0] DT_Q    = 32'(DT_FIXED);

   // {clip, value}
   function automatic logic [32:0] sat32(input logic signed [63:0] v);
      logic [32:0] r;
      priority if (v > S32_MAX) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < S32_MIN) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   logic signed [31:0] x_ff [4];
   logic signed [31:0] x_in [4];
   logic signed [31:0] acc_ff, acc_in, u_ff, u_in, r1_ff, r1_in, r3_ff, r3_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               clip_ff, clip_in;
   logic [1:0]         idx_ff;
   logic signed [31:0] val_ff;

   logic signed [31:0] pos_ff, vel_ff, ang_ff, rate_ff, drv_ff;
   logic               sat_ff, sat_in;

   logic signed [31:0] mul_a, mul_b, addend, q, sum, u_new;
   logic signed [63:0] rnd_prod, shifted;
   logic signed [32:0] raw_sum;
   logic [32:0]        q_sat, s_sat;
   logic               n_clip, clip_now, clip_cnt;

   // operand select
   always_comb begin
      unique case (ctrl.cw.mul_a)
         sefs_pkg::MA_G0:  mul_a = csr_regs[sefs_pkg::CSR_GAIN_POS];
         sefs_pkg::MA_G1:  mul_a = csr_regs[sefs_pkg::CSR_GAIN_VEL];
         sefs_pkg::MA_G2:  mul_a = csr_regs[sefs_pkg::CSR_GAIN_ANG];
         sefs_pkg::MA_G3:  mul_a = csr_regs[sefs_pkg::CSR_GAIN_RATE];
         sefs_pkg::MA_A12: mul_a = csr_regs[sefs_pkg::CSR_ANG_TO_ACC];
         sefs_pkg::MA_A32: mul_a = csr_regs[sefs_pkg::CSR_ANG_TO_ANGAC];
         sefs_pkg::MA_B1:  mul_a = csr_regs[sefs_pkg::CSR_DRV_TO_ACC];
         sefs_pkg::MA_B3:  mul_a = csr_regs[sefs_pkg::CSR_DRV_TO_ANGAC];
         sefs_pkg::MA_X1:  mul_a = x_ff[1];
         sefs_pkg::MA_X3:  mul_a = x_ff[3];
         sefs_pkg::MA_R1:  mul_a = r1_ff;
         sefs_pkg::MA_R3:  mul_a = r3_ff;
         default:          mul_a = '0;
      endcase
      unique case (ctrl.cw.mul_b)
         sefs_pkg::MB_X0: mul_b = x_ff[0];
         sefs_pkg::MB_X1: mul_b = x_ff[1];
         sefs_pkg::MB_X2: mul_b = x_ff[2];
         sefs_pkg::MB_X3: mul_b = x_ff[3];
         sefs_pkg::MB_U:  mul_b = u_ff;
         sefs_pkg::MB_DT: mul_b = DT_Q;
         default:         mul_b = '0;
      endcase
      unique case (ctrl.cw.wb_add)
         sefs_pkg::AS_ZERO: addend = '0;
         sefs_pkg::AS_ACC:  addend = acc_ff;
         sefs_pkg::AS_R1:   addend = r1_ff;
         sefs_pkg::AS_R3:   addend = r3_ff;
         sefs_pkg::AS_X0:   addend = x_ff[0];
         sefs_pkg::AS_X1:   addend = x_ff[1];
         sefs_pkg::AS_X2:   addend = x_ff[2];
         sefs_pkg::AS_X3:   addend = x_ff[3];
         default:           addend = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // round, floor shift, clip, then saturating add
   assign rnd_prod = prod_ff + RND;
   assign shifted  = rnd_prod >>> FRAC_BITS;
   assign q_sat    = sat32(shifted);
   assign q        = q_sat[31:0];
   assign raw_sum  = 33'(addend) + 33'(q);
   assign s_sat    = sat32(64'(raw_sum));
   assign sum      = s_sat[31:0];

   assign n_clip   = (acc_ff == 32'sh8000_0000);
   assign u_new    = n_clip ? 32'sh7FFF_FFFF : -acc_ff;

   // the drive negation is part of every word; plant products only of advances
   assign clip_now = ctrl.cw.wb_en && (q_sat[32] || s_sat[32]);
   assign clip_cnt = (clip_now && !(ctrl.cw.adv_only && ctrl.is_load))
                     || (ctrl.cw.neg && n_clip);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         x_in[i] = x_ff[i];
      end
      acc_in  = acc_ff;
      u_in    = u_ff;
      r1_in   = r1_ff;
      r3_in   = r3_ff;
      clip_in = clip_ff;
      sat_in  = sat_ff;
      if (ctrl.start) begin
         clip_in = 1'b0;
      end else if (ctrl.adv) begin
         clip_in = clip_ff || clip_cnt;
         if (ctrl.cw.wb_en) begin
            unique case (ctrl.cw.wb_dst)
               sefs_pkg::DS_ACC: acc_in  = sum;
               sefs_pkg::DS_R1:  r1_in   = sum;
               sefs_pkg::DS_R3:  r3_in   = sum;
               sefs_pkg::DS_X0:  x_in[0] = sum;
               sefs_pkg::DS_X1:  x_in[1] = sum;
               sefs_pkg::DS_X2:  x_in[2] = sum;
               sefs_pkg::DS_X3:  x_in[3] = sum;
               default:          acc_in  = acc_ff;
            endcase
         end
         if (ctrl.cw.neg) begin
            u_in = u_new;
         end
         if (ctrl.cw.load) begin
            x_in[idx_ff] = val_ff;
         end
         if (ctrl.cw.last) begin
            sat_in = clip_ff || clip_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff[0] <= sefs_pkg::X0_RESET;
         x_ff[1] <= sefs_pkg::X1_RESET;
         x_ff[2] <= sefs_pkg::X2_RESET;
         x_ff[3] <= sefs_pkg::X3_RESET;
         clip_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            x_ff[i] <= x_in[i];
         end
         clip_ff <= clip_in;
         sat_ff  <= sat_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      u_ff   <= u_in;
      r1_ff  <= r1_in;
      r3_ff  <= r3_in;
      if (ctrl.adv) begin
         prod_ff <= prod_in;
      end
      if (ctrl.start) begin
         idx_ff <= req_entry_index;
         val_ff <= req_entry_value;
      end
      if (ctrl.adv && ctrl.cw.emit) begin
         pos_ff  <= x_ff[0];
         vel_ff  <= x_ff[1];
         ang_ff  <= x_ff[2];
         rate_ff <= x_ff[3];
         drv_ff  <= u_new;
      end
   end

   assign rsp_position_now     = pos_ff;
   assign rsp_velocity_now     = vel_ff;
   assign rsp_angle_now        = ang_ff;
   assign rsp_angular_rate_now = rate_ff;
   assign rsp_drive_value      = drv_ff;
   assign rsp_saturated        = sat_ff;

endmodule

FILE: hdl/state_feedback_euler_step.sv
// ---------------------------------------------------------------------------
// state_feedback_euler_step: LQR state feedback with Euler plant update
// Reports state and drive u = -(K.x), then advances x += dt*(A.x + B.u) or
// loads one entry, in saturating Q11.20, by microcode ROM over one multiplier.
// ---------------------------------------------------------------------------
//
//   channel | ports                           | handshake    | direction
//   --------+---------------------------------+--------------+----------
//   req     | func, entry_index, entry_value  | valid/ready  | in
//   rsp     | state now, drive, saturated     | valid/ready  | out
//   csr     | index, write_data               | write_en     | in
//
// An advance word runs steps 0-12, a load word steps 0-5 and the load step:
// one step per cycle unless held at the drive step, one product through the
// shared 32x32 multiplier per step, retired (round, clip, add) a step later.
// Reset is synchronous: state returns to rest with the pole at 0.1 rad and
// the registers to their default gains and plant terms.
// The output word is written at the drive step; if the previous word is
// still unread, the sequencer holds there until rsp_ready frees it.
// A new request is taken as soon as the sequencer is idle, even while the
// last result still waits.
module state_feedback_euler_step #(
   parameter int FRAC_BITS = 20,
   parameter int DT_FIXED  = 20972
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request words
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [1:0]                            req_entry_index,
   input  logic signed [31:0]                    req_entry_value,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [31:0]                    rsp_position_now,
   output logic signed [31:0]                    rsp_velocity_now,
   output logic signed [31:0]                    rsp_angle_now,
   output logic signed [31:0]                    rsp_angular_rate_now,
   output logic signed [31:0]                    rsp_drive_value,
   output logic                                  rsp_saturated,
   // register writes
   input  logic                                  csr_write_en,
   input  logic [sefs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sefs_pkg::DATA_W-1:0]           csr_write_data
);

   sefs_pkg::seq_ctrl_type  ctrl;
   sefs_pkg::csr_array_type csr_regs;

   // gains K, couplings A(1,2)/A(3,2), drive terms B(1)/B(3)
   sefs_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .csr_regs       (csr_regs)
   );

   // step counter + control ROM; branches load words to the load step after the drive
   sefs_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // multiplier, rounding/clip stage, state and scratch registers
   sefs_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .DT_FIXED  (DT_FIXED)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .csr_regs             (csr_regs),
      .req_entry_index      (req_entry_index),
      .req_entry_value      (req_entry_value),
      .rsp_position_now     (rsp_position_now),
      .rsp_velocity_now     (rsp_velocity_now),
      .rsp_angle_now        (rsp_angle_now),
      .rsp_angular_rate_now (rsp_angular_rate_now),
      .rsp_drive_value      (rsp_drive_value),
      .rsp_saturated        (rsp_saturated)
   );

endmodule

FILE: hdl/sefs_checker.sv
// ---------------------------------------------------------------------------
// sefs_checker: port-level checks for the Euler stepper
// Watches the handshakes over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module sefs_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_func,
   input logic [1:0]                            req_entry_index,
   input logic signed [31:0]                    req_entry_value,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [31:0]                    rsp_position_now,
   input logic signed [31:0]                    rsp_velocity_now,
   input logic signed [31:0]                    rsp_angle_now,
   input logic signed [31:0]                    rsp_angular_rate_now,
   input logic signed [31:0]                    rsp_drive_value,
   input logic                                  rsp_saturated,
   input logic                                  csr_write_en,
   input logic [sefs_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [sefs_pkg::DATA_W-1:0]           csr_write_data
);

   // one word in flight: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in flight");

   // a result never appears the cycle after acceptance
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result raised too early");

   // finishing a word frees the request side at the same edge
   a_done_frees_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while sequencer still busy");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_value)
         && $stable(rsp_saturated) && $stable(rsp_angle_now))
      else $error("result dropped or changed under stall");

endmodule

bind state_feedback_euler_step sefs_checker u_sefs_checker (.*);

FILE: tb/sefs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sefs_scoreboard: scoreboard for the state feedback Euler stepper
// Watches the csr, req and rsp ports, keeps its own copy of the plant state
// and coefficients, predicts each report word and compares it on arrival.
// ---------------------------------------------------------------------------
module sefs_scoreboard #(
   parameter int FRAC_BITS = 20,
   parameter int DT_FIXED  = 20972
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_func,
   input  logic [1:0]                         req_entry_index,
   input  logic signed [31:0]                 req_entry_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [31:0]                 rsp_position_now,
   input  logic signed [31:0]                 rsp_velocity_now,
   input  logic signed [31:0]                 rsp_angle_now,
   input  logic signed [31:0]                 rsp_angular_rate_now,
   input  logic signed [31:0]                 rsp_drive_value,
   input  logic                               rsp_saturated,
   input  logic                               csr_write_en,
   input  logic [sefs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sefs_pkg::DATA_W-1:0]        csr_write_data,
   output int                                 fail_count,
   output int                                 pending_words,
   output int                                 checked_words,
   output int                                 clipped_words
);

   localparam int ST_POS  = 0;
   localparam int ST_VEL  = 1;
   localparam int ST_ANG  = 2;
   localparam int ST_RATE = 3;

   localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_LO = -S32_HI - 1;
   localparam logic signed [31:0] DT_Q = DT_FIXED;

   typedef struct packed {
      logic signed [31:0] position_now;
      logic signed [31:0] velocity_now;
      logic signed [31:0] angle_now;
      logic signed [31:0] angular_rate_now;
      logic signed [31:0] drive_value;
      logic               saturated;
   } step_report_type;

   logic signed [31:0] plant_state [4];
   logic signed [31:0] coeff [8];
   bit                 clip_seen;
   step_report_type    awaited_reports [$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
      checked_words = 0;
      clipped_words = 0;
   end

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > S32_HI) begin
         clip_seen = 1'b1;
         return S32_HI[31:0];
      end
      if (v < S32_LO) begin
         clip_seen = 1'b1;
         return S32_LO[31:0];
      end
      return v[31:0];
   endfunction

   // round half up, floor shift, then clip
   function automatic logic signed [31:0] sat_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      longint prod;
      prod = longint'(a) * longint'(b) + (longint'(1) << (FRAC_BITS - 1));
      return clip32(prod >>> FRAC_BITS);
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return clip32(longint'(a) + longint'(b));
   endfunction

   // u = -(K.x), summed left to right
   function automatic logic signed [31:0] feedback_drive();
      logic signed [31:0] acc;
      acc = sat_mul(coeff[sefs_pkg::CSR_GAIN_POS], plant_state[ST_POS]);
      acc = sat_add(acc, sat_mul(coeff[sefs_pkg::CSR_GAIN_VEL], plant_state[ST_VEL]));
      acc = sat_add(acc, sat_mul(coeff[sefs_pkg::CSR_GAIN_ANG], plant_state[ST_ANG]));
      acc = sat_add(acc, sat_mul(coeff[sefs_pkg::CSR_GAIN_RATE], plant_state[ST_RATE]));
      return clip32(-longint'(acc));
   endfunction

   function automatic step_report_type predict_report(input logic func,
                                                      input logic [1:0] idx,
                                                      input logic signed [31:0] value);
      step_report_type    rep;
      logic signed [31:0] u;
      logic signed [31:0] rate [4];
      int                 i;
      clip_seen             = 1'b0;
      u                     = feedback_drive();
      rep.position_now      = plant_state[ST_POS];
      rep.velocity_now      = plant_state[ST_VEL];
      rep.angle_now         = plant_state[ST_ANG];
      rep.angular_rate_now  = plant_state[ST_RATE];
      rep.drive_value       = u;
      if (func == sefs_pkg::FUNC_LOAD) begin
         rep.saturated    = clip_seen;
         plant_state[idx] = value;
      end else begin
         rate[ST_POS]  = plant_state[ST_VEL];
         rate[ST_VEL]  = sat_add(sat_mul(coeff[sefs_pkg::CSR_ANG_TO_ACC],
                                         plant_state[ST_ANG]),
                                 sat_mul(coeff[sefs_pkg::CSR_DRV_TO_ACC], u));
         rate[ST_ANG]  = plant_state[ST_RATE];
         rate[ST_RATE] = sat_add(sat_mul(coeff[sefs_pkg::CSR_ANG_TO_ANGAC],
                                         plant_state[ST_ANG]),
                                 sat_mul(coeff[sefs_pkg::CSR_DRV_TO_ANGAC], u));
         for (i = 0; i < 4; i++)
            plant_state[i] = sat_add(plant_state[i], sat_mul(rate[i], DT_Q));
         rep.saturated = clip_seen;
      end
      return rep;
   endfunction

   task automatic check_field(input string what, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      step_report_type want;
      if (reset) begin
         coeff[sefs_pkg::CSR_GAIN_POS]     = -32'sd1048576;
         coeff[sefs_pkg::CSR_GAIN_VEL]     = -32'sd1572864;
         coeff[sefs_pkg::CSR_GAIN_ANG]     = -32'sd20971520;
         coeff[sefs_pkg::CSR_GAIN_RATE]    = -32'sd3145728;
         coeff[sefs_pkg::CSR_ANG_TO_ACC]   = -32'sd1028653;
         coeff[sefs_pkg::CSR_ANG_TO_ANGAC] = 32'sd22630367;
         coeff[sefs_pkg::CSR_DRV_TO_ACC]   = 32'sd1048576;
         coeff[sefs_pkg::CSR_DRV_TO_ANGAC] = -32'sd2097152;
         plant_state[ST_POS]     = 32'sd0;
         plant_state[ST_VEL]     = 32'sd0;
         plant_state[ST_ANG]     = 32'sd104858;
         plant_state[ST_RATE]    = 32'sd0;
         awaited_reports.delete();
      end else begin
         if (csr_write_en)
            coeff[csr_index] = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (awaited_reports.size() == 0) begin
               fail_count++;
               $display("%0t ns: report word with none expected, drive %0d", $time,
                        rsp_drive_value);
            end else begin
               want = awaited_reports.pop_front();
               check_field("position_now", want.position_now, rsp_position_now);
               check_field("velocity_now", want.velocity_now, rsp_velocity_now);
               check_field("angle_now", want.angle_now, rsp_angle_now);
               check_field("angular_rate_now", want.angular_rate_now,
                           rsp_angular_rate_now);
               check_field("drive_value", want.drive_value, rsp_drive_value);
               check_field("saturated", 32'(want.saturated), 32'(rsp_saturated));
               checked_words++;
               if (want.saturated)
                  clipped_words++;
            end
         end
         if (req_valid && req_ready)
            awaited_reports.push_back(predict_report(req_func, req_entry_index,
                                                     req_entry_value));
      end
      pending_words = awaited_reports.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for state_feedback_euler_step
// Drives load and advance words with random idling on both channels, steps
// through several coefficient sets and lets sefs_scoreboard score the reports.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int FRAC_BITS     = 20;
   localparam int DT_FIXED      = 20972;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 150;
   localparam int SETTLE_CYCLES = 20;    // quiet margin before register writes
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   // coefficient sets applied between phases
   typedef enum int {
      CS_DEFAULT, CS_SMALL, CS_MAX, CS_MIN, CS_ZERO, CS_FULL, CS_MIXED
   } coeff_set_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [1:0]  req_entry_index;
   logic signed [31:0] req_entry_value;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_position_now;
   logic signed [31:0] rsp_velocity_now;
   logic signed [31:0] rsp_angle_now;
   logic signed [31:0] rsp_angular_rate_now;
   logic signed [31:0] rsp_drive_value;
   logic        rsp_saturated;
   logic        csr_write_en;
   logic [sefs_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sefs_pkg::DATA_W-1:0]    csr_write_data;

   int fail_count;
   int pending_words;
   int checked_words;
   int clipped_words;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int loads_sent      = 0;
   int advances_sent   = 0;

   // one mild set early, the extremes, then a mix
   coeff_set_type phase_plan [PHASES] = '{CS_SMALL, CS_MAX, CS_DEFAULT, CS_MIN,
                                          CS_FULL, CS_ZERO, CS_MIXED, CS_SMALL};

   always #5 clock = ~clock;

   state_feedback_euler_step #(
      .FRAC_BITS (FRAC_BITS),
      .DT_FIXED  (DT_FIXED)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_entry_index      (req_entry_index),
      .req_entry_value      (req_entry_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_position_now     (rsp_position_now),
      .rsp_velocity_now     (rsp_velocity_now),
      .rsp_angle_now        (rsp_angle_now),
      .rsp_angular_rate_now (rsp_angular_rate_now),
      .rsp_drive_value      (rsp_drive_value),
      .rsp_saturated        (rsp_saturated),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   sefs_scoreboard #(
      .FRAC_BITS (FRAC_BITS),
      .DT_FIXED  (DT_FIXED)
   ) checker_i (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_entry_index      (req_entry_index),
      .req_entry_value      (req_entry_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_position_now     (rsp_position_now),
      .rsp_velocity_now     (rsp_velocity_now),
      .rsp_angle_now        (rsp_angle_now),
      .rsp_angular_rate_now (rsp_angular_rate_now),
      .rsp_drive_value      (rsp_drive_value),
      .rsp_saturated        (rsp_saturated),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .fail_count           (fail_count),
      .pending_words        (pending_words),
      .checked_words        (checked_words),
      .clipped_words        (clipped_words)
   );

   // receiver: random backpressure, redrawn every cycle
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // Realistic values sit within +-4.0 so trajectories evolve without
   // clipping; otherwise favor the rails and full-range noise.
   function automatic logic [31:0] pick_value(input bit realistic);
      int v;
      if (realistic) begin
         v = int'($urandom_range(8388608)) - 4194304;
         return v;
      end
      case ($urandom_range(5))
         0: return Q_MAX;
         1: return Q_MIN;
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge, returns at the falling edge after acceptance.
   // Valid stays high into the next word unless an idle gap is drawn.
   task automatic send_word(input logic func, input logic [1:0] idx,
                            input logic [31:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_entry_index <= idx;
      req_entry_value <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      if (func == sefs_pkg::FUNC_LOAD)
         loads_sent++;
      else
         advances_sent++;
   endtask

   // wait for every report, then leave the block idle as a settling margin
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_words != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_coeffs(input coeff_set_type kind);
      logic [sefs_pkg::CSR_IDX_W-1:0] idx;
      logic [31:0]                    data;
      int                             i;
      for (i = 0; i < sefs_pkg::NUM_CSR; i++) begin
         idx = i[sefs_pkg::CSR_IDX_W-1:0];
         case (kind)
            CS_DEFAULT: begin
               case (idx)
                  sefs_pkg::CSR_GAIN_POS:     data = -32'sd1048576;
                  sefs_pkg::CSR_GAIN_VEL:     data = -32'sd1572864;
                  sefs_pkg::CSR_GAIN_ANG:     data = -32'sd20971520;
                  sefs_pkg::CSR_GAIN_RATE:    data = -32'sd3145728;
                  sefs_pkg::CSR_ANG_TO_ACC:   data = -32'sd1028653;
                  sefs_pkg::CSR_ANG_TO_ANGAC: data = 32'sd22630367;
                  sefs_pkg::CSR_DRV_TO_ACC:   data = 32'sd1048576;
                  default:                    data = -32'sd2097152;
               endcase
            end
            CS_SMALL: data = int'($urandom_range(16777216)) - 8388608;   // +-8.0
            CS_MAX:   data = Q_MAX;
            CS_MIN:   data = Q_MIN;
            CS_ZERO:  data = '0;
            CS_FULL:  data = $urandom;
            default: begin
               case ($urandom_range(3))
                  0: data = Q_MAX;
                  1: data = Q_MIN;
                  2: data = '0;
                  default: data = int'($urandom_range(16777216)) - 8388608;
               endcase
            end
         endcase
         csr_write_en   <= 1'b1;
         csr_index      <= idx;
         csr_write_data <= data;
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // watchdog
   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      int p;
      int i;
      int n;
      int phase_start;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = sefs_pkg::FUNC_ADVANCE;
      req_entry_index = '0;
      req_entry_value = '0;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_write_data  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: reset coefficients, no idling ---
      // two steps from the rest state with the pole tilted
      send_word(sefs_pkg::FUNC_ADVANCE, 2'd0, 32'd0);
      send_word(sefs_pkg::FUNC_ADVANCE, 2'd0, 32'd0);
      // every entry at the top rail, then an advance with its ignored
      // fields at their opposite extremes
      for (i = 0; i < 4; i++)
         send_word(sefs_pkg::FUNC_LOAD, i[1:0], Q_MAX);
      send_word(sefs_pkg::FUNC_ADVANCE, 2'd3, Q_MIN);
      // every entry at the bottom rail, two advances into heavy clipping
      for (i = 0; i < 4; i++)
         send_word(sefs_pkg::FUNC_LOAD, i[1:0], Q_MIN);
      send_word(sefs_pkg::FUNC_ADVANCE, 2'd3, Q_MAX);
      send_word(sefs_pkg::FUNC_ADVANCE, 2'd0, 32'hFFFF_FFFF);
      // one lsb either side of zero, back to a sane trajectory
      send_word(sefs_pkg::FUNC_LOAD, 2'd0, 32'hFFFF_FFFF);
      send_word(sefs_pkg::FUNC_LOAD, 2'd1, 32'd1);
      send_word(sefs_pkg::FUNC_LOAD, 2'd2, 32'd0);
      send_word(sefs_pkg::FUNC_LOAD, 2'd3, 32'd0);
      send_word(sefs_pkg::FUNC_ADVANCE, 2'd1, 32'h5555_AAAA);
      send_word(sefs_pkg::FUNC_ADVANCE, 2'd2, 32'hAAAA_5555);
      drain_block();

      // --- random phases: one coefficient set and one idle pattern each ---
      for (p = 0; p < PHASES; p++) begin
         write_coeffs(phase_plan[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 64; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 64; end
            default: begin sender_idle_pct = 7; stall_pct = 7; end
         endcase
         phase_start = loads_sent + advances_sent;
         while (loads_sent + advances_sent - phase_start < PHASE_WORDS) begin
            if ($urandom_range(9) < 7) begin
               // trajectory: seed a few entries, then run the plant
               n = $urandom_range(4);
               repeat (n) send_word(sefs_pkg::FUNC_LOAD, 2'($urandom_range(3)),
                                    pick_value(1'b1));
               n = $urandom_range(30, 5);
               repeat (n) send_word(sefs_pkg::FUNC_ADVANCE, 2'($urandom_range(3)),
                                    $urandom);
            end else begin
               send_word(1'($urandom_range(1)), 2'($urandom_range(3)),
                         pick_value(1'b0));
            end
         end
         drain_block();
      end
      sender_idle_pct = 0;
      stall_pct       = 0;

      $display("summary: %0d words checked (%0d loads, %0d advances), %0d with clipping",
               checked_words, loads_sent, advances_sent, clipped_words);
      $display("summary: directed rails plus %0d coefficient sets over four idle patterns",
               PHASES);
      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/sefs_pkg.sv
hdl/sefs_csr.sv
hdl/sefs_sequencer.sv
hdl/sefs_datapath.sv
hdl/state_feedback_euler_step.sv
hdl/sefs_checker.sv
tb/sefs_checker.sv
tb/tb_top.sv
